[sv/rfcc_pkg.sv]
`timescale 1ns / 1ps
// Rainflow cycle counter package: sizes, result codes, stack entry and cycle types,
// and the range / mean / period arithmetic used by the core.
package rfcc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int VAL_W    = 24;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int RANGE_W  = 24;
  localparam int MEAN_W   = 25;
  localparam int PERIOD_W = 33;

  // cycle_kind codes
  localparam logic [KIND_W-1:0] KIND_HALF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVF  = 2'd2;

  // one stack entry: reversal point value and its time stamp
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // one counted cycle, without the end-of-run flag
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [RANGE_W-1:0]  range_v;
    logic [MEAN_W-1:0]   mean;
    logic [TIME_W-1:0]   start;
    logic [PERIOD_W-1:0] period;
  } cycle_t;

  // |a - b| of two signed values; the magnitude always fits RANGE_W bits
  function automatic logic [RANGE_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
    logic signed [VAL_W:0] d;
    d = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
    if (d < 0) begin
      d = -d;
    end
    return d[RANGE_W-1:0];
  endfunction

  // cycle between an older and a newer point: range, doubled mean, start, doubled period
  function automatic cycle_t make_cycle(input logic [KIND_W-1:0] kind,
                                        input entry_t older,
                                        input entry_t newer);
    cycle_t            c;
    logic [TIME_W-1:0] dt;
    dt        = newer.stamp - older.stamp;
    c.kind    = kind;
    c.range_v = abs_diff(older.value, newer.value);
    c.mean    = {older.value[VAL_W-1], older.value} + {newer.value[VAL_W-1], newer.value};
    c.start   = older.stamp;
    c.period  = {dt, 1'b0};
    return c;
  endfunction

endpackage

[sv/rainflow_cycle_counter_core.sv]
`timescale 1ns / 1ps
// Rainflow cycle counter core: reversal-point stack in a two-read-port RAM,
// pop sequencer, result holding register and output register. Uses rfcc_pkg.
//
// Takes one request beat at a time (push a reversal point or flush the residual
// stack) and returns one result beat per counted non-zero-range cycle, the last
// of a request marked by last_of_run; a push onto a full stack returns one
// overflow beat. A push goes straight to finish while the stack holds fewer
// than two entries, else through a compare, then finish; each full cycle popped
// adds a registered stack RAM read of the new entries below the top, then the
// next compare, which is skipped when it leaves two entries; a half cycle adds
// a state for its second RAM write. A flush reads every adjacent pair from the
// RAM into the read registers, then emits it. Result beats wait in a holding
// register so the final one can be marked, plus an output register; a stalled
// output stalls the pop sequencer.
// The stack RAM needs no clear after reset: entries at or above the count are
// never used.
module rainflow_cycle_counter_core import rfcc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic [0:0]               req_type,
  input  logic signed [VAL_W-1:0]  point_value,
  input  logic [TIME_W-1:0]        point_time,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [KIND_W-1:0]        cycle_kind,
  output logic [RANGE_W-1:0]       range_value,
  output logic signed [MEAN_W-1:0] mean_doubled,
  output logic [TIME_W-1:0]        start_time,
  output logic [PERIOD_W-1:0]      period,
  output logic [0:0]               last_of_run
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_HALFW = 3'd3;
  localparam logic [2:0] ST_FLRD  = 3'd4;
  localparam logic [2:0] ST_FLEM  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_3    = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_4    = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_5    = CNT_W'(5);

  // stack RAM, one write and two registered reads
  entry_t             mem [STACK_DEPTH];
  entry_t             rd_a, rd_b, wd;
  logic [ADDR_W-1:0]  ra, rb, wa;
  logic               we;

  // control and datapath registers
  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;     // entries on the stack
  logic [CNT_W-1:0] fi, fi_next;       // flush pair index
  entry_t           top, top_next;     // point being pushed
  entry_t           r1, r1_next;       // entry below top (top itself when idle)
  entry_t           r2, r2_next;       // entry below r1
  cycle_t           pend, pend_next;   // result waiting to learn if it is last
  logic             pend_valid, pend_valid_next;

  logic [CNT_W-1:0]   cnt_m3, cnt_m4, cnt_m5, fi_p1, fi_p2;
  logic [RANGE_W-1:0] older_rng, newer_rng;
  logic               pop, can_emit, emit, mv, mv_last;
  cycle_t             cmp_cyc, fl_cyc, emit_cyc, ovf_cyc;
  entry_t             point;

  assign point  = '{value: point_value, stamp: point_time};
  assign cnt_m3 = cnt - CNT_3;
  assign cnt_m4 = cnt - CNT_4;
  assign cnt_m5 = cnt - CNT_5;
  assign fi_p1  = fi + CNT_ONE;
  assign fi_p2  = fi + CNT_TWO;

  // rainflow test: older range no larger than newest range
  assign older_rng = abs_diff(r1.value, r2.value);
  assign newer_rng = abs_diff(top.value, r1.value);
  assign pop       = (older_rng <= newer_rng);

  assign cmp_cyc = make_cycle((cnt == CNT_3) ? KIND_HALF : KIND_FULL, r2, r1);
  assign fl_cyc  = make_cycle(KIND_HALF, rd_a, rd_b);
  assign ovf_cyc = '{kind: KIND_OVF, default: '0};

  assign item_ready = (state == ST_IDLE);
  // a new result may enter the holding register if the held one can move out
  assign can_emit   = !pend_valid || !result_valid || result_ready;

  // RAM port control
  always_comb begin
    we = 1'b0;
    wa = cnt[ADDR_W-1:0];
    wd = point;
    ra = cnt_m4[ADDR_W-1:0];
    rb = cnt_m5[ADDR_W-1:0];
    case (state)
      ST_IDLE: begin
        if (item_valid && !req_type[0] && cnt != CNT_FULL) begin
          we = 1'b1;
        end
      end
      ST_CMP: begin
        if (pop && can_emit) begin
          we = 1'b1;
          if (cnt == CNT_3) begin
            wa = '0;
            wd = r1;
          end else begin
            wa = cnt_m3[ADDR_W-1:0];
            wd = top;
          end
        end
      end
      ST_HALFW: begin
        we = 1'b1;
        wa = CNT_ONE[ADDR_W-1:0];
        wd = top;
      end
      // pair address held while the pair waits to be emitted
      ST_FLRD, ST_FLEM: begin
        ra = fi[ADDR_W-1:0];
        rb = fi_p1[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // sequencer
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    fi_next         = fi;
    top_next        = top;
    r1_next         = r1;
    r2_next         = r2;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    emit            = 1'b0;
    emit_cyc        = cmp_cyc;
    mv              = 1'b0;
    mv_last         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (req_type[0]) begin
            fi_next = '0;
            if (cnt >= CNT_TWO) begin
              state_next = ST_FLRD;
            end else begin
              cnt_next   = '0;
              state_next = ST_FIN;
            end
          end else if (cnt == CNT_FULL) begin
            pend_next       = ovf_cyc;
            pend_valid_next = 1'b1;
            state_next      = ST_FIN;
          end else begin
            top_next = point;
            cnt_next = cnt + CNT_ONE;
            if (cnt >= CNT_TWO) begin
              state_next = ST_CMP;
            end else begin
              r2_next    = r1;
              r1_next    = point;
              state_next = ST_FIN;
            end
          end
        end
      end
      ST_CMP: begin
        if (!pop) begin
          r2_next    = r1;
          r1_next    = top;
          state_next = ST_FIN;
        end else if (can_emit) begin
          emit = (cmp_cyc.range_v != '0);
          if (cnt == CNT_3) begin
            // half cycle: bottom entry drops, stack becomes {r1, top}
            cnt_next   = CNT_TWO;
            r2_next    = r1;
            r1_next    = top;
            state_next = ST_HALFW;
          end else begin
            // full cycle: r2 and r1 leave, top slides down
            cnt_next   = cnt - CNT_TWO;
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (cnt >= CNT_3) begin
          r1_next    = rd_a;
          r2_next    = rd_b;
          state_next = ST_CMP;
        end else begin
          r2_next    = rd_a;
          r1_next    = top;
          state_next = ST_FIN;
        end
      end
      ST_HALFW: begin
        state_next = ST_FIN;
      end
      ST_FLRD: begin
        state_next = ST_FLEM;
      end
      ST_FLEM: begin
        emit_cyc = fl_cyc;
        if (can_emit) begin
          emit = (fl_cyc.range_v != '0);
          if (fi_p2 < cnt) begin
            fi_next    = fi_p1;
            state_next = ST_FLRD;
          end else begin
            cnt_next   = '0;
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (!result_valid || result_ready) begin
          mv              = 1'b1;
          mv_last         = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // a fresh result pushes the held one out, marked not last
    if (emit) begin
      if (pend_valid) begin
        mv = 1'b1;
      end
      pend_next       = emit_cyc;
      pend_valid_next = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      fi           <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      fi         <= fi_next;
      pend_valid <= pend_valid_next;
      if (mv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top  <= top_next;
    r1   <= r1_next;
    r2   <= r2_next;
    pend <= pend_next;
    if (mv) begin
      cycle_kind   <= pend.kind;
      range_value  <= pend.range_v;
      mean_doubled <= $signed(pend.mean);
      start_time   <= pend.start;
      period       <= pend.period;
      last_of_run  <= mv_last;
    end
  end

endmodule

[sv/rfcc_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the rainflow cycle counter core, bound to the core module.
// Uses rfcc_pkg for widths and cycle_kind codes.
module rfcc_checker import rfcc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     item_valid,
  input logic                     item_ready,
  input logic [0:0]               req_type,
  input logic signed [VAL_W-1:0]  point_value,
  input logic [TIME_W-1:0]        point_time,
  input logic                     result_valid,
  input logic                     result_ready,
  input logic [KIND_W-1:0]        cycle_kind,
  input logic [RANGE_W-1:0]       range_value,
  input logic signed [MEAN_W-1:0] mean_doubled,
  input logic [TIME_W-1:0]        start_time,
  input logic [PERIOD_W-1:0]      period,
  input logic [0:0]               last_of_run
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(cycle_kind)
      && $stable(range_value) && $stable(mean_doubled) && $stable(start_time)
      && $stable(period) && $stable(last_of_run))
    else $error("result beat changed while stalled");

  // one request at a time: no new beat taken right after one is accepted
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while previous one still in work");

  // overflow beat is a lone, empty, final result
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    result_valid && cycle_kind == KIND_OVF |-> range_value == '0
      && mean_doubled == '0 && period == '0 && last_of_run[0])
    else $error("malformed overflow beat");

  // counted cycles never have zero range
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (cycle_kind == KIND_HALF || cycle_kind == KIND_FULL)
      |-> range_value != '0)
    else $error("zero-range cycle reported");

  // a+b and |a-b| always share parity
  a_parity: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> mean_doubled[0] == range_value[0])
    else $error("mean and range parity mismatch");

endmodule

bind rainflow_cycle_counter_core rfcc_checker u_rfcc_checker (.*);
